/* hw/rtl/ipbl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ipbl_pkg: shared types and constants for the IP blocklist
// Command, event and register codes, payload structs.
// ---------------------------------------------------------------------------
package ipbl_pkg;
	localparam int Capacity = 32;
	localparam int IdxW = $clog2(Capacity);
	localparam int CntW = $clog2(Capacity + 1);

	typedef enum logic [2:0] {
		CMD_PACKET = 3'd0, CMD_TICK = 3'd1, CMD_ADD = 3'd2,
		CMD_DELETE = 3'd3, CMD_CLEAR = 3'd4, CMD_RSV5 = 3'd5,
		CMD_RSV6 = 3'd6, CMD_RSV7 = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		EV_PASS = 3'd0, EV_DROPPED = 3'd1, EV_LISTED = 3'd2, EV_FRESHENED = 3'd3,
		EV_DELETED = 3'd4, EV_FULL = 3'd5, EV_CLEARED = 3'd6, EV_NOTHING = 3'd7
	} event_t;

	localparam logic [2:0] REG_HOLD = 3'd0;
	localparam logic [2:0] REG_REFRESH = 3'd1;
	localparam logic [2:0] REG_FILTER = 3'd2;
	localparam logic [2:0] REG_WATCH = 3'd3;
	localparam logic [2:0] REG_TRAP_A = 3'd4;
	localparam logic [2:0] REG_TRAP_B = 3'd5;
	localparam logic [2:0] REG_SMTP = 3'd6;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [15:0] PORT_NB_LO = 16'd137;
	localparam logic [15:0] PORT_NB_HI = 16'd139;
	localparam logic [15:0] PORT_SMTP = 16'd25;

	typedef struct packed {
		logic [2:0] command;
		logic [31:0] address;
		logic [31:0] dest_addr;
		logic [3:0] ip_version;
		logic is_fragment;
		logic [7:0] protocol;
		logic [15:0] dest_port;
		logic [7:0] arrival_interface;
		logic [15:0] packet_length;
	} in_item_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic drop;
		logic [31:0] notice_addr;
		logic [15:0] notice_length;
		logic [5:0] entry_count;
		logic [63:0] change_serial;
		logic last;
	} out_item_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/ip_blocklist_with_aging.sv */
`timescale 1ns / 1ps
`default_nettype none
// A packet, add or delete scans all 32 entries, one memory read per cycle, then decides;
// a result that may write an entry passes through the write state before it is registered.
// Clear and unused commands answer in the cycle after acceptance. A tick rescans once per
// expired entry and gives one result per rescan; an output stall holds the next rescan.
// One transaction in flight; the next is taken once its final result has been accepted.
// Reset (asynchronous, active low) clears valid bits, count, clock, serial; registers take defaults.
// ---------------------------------------------------------------------------
// ip_blocklist_with_aging: IPv4 source blocklist with expiry and refresh
// Entries live in a synchronous memory that a sequencer scans and updates.
// ---------------------------------------------------------------------------
module ip_blocklist_with_aging
	import ipbl_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DECIDE, ST_WRITE, ST_OUT} state_t;

	// entry memory: address, expiry, refresh
	logic [95:0] mem [Capacity];
	logic [95:0] rd_s1;
	logic [Capacity-1:0] valid_q;

	logic [31:0] hold_q, refr_q, trap_a_q, trap_b_q, smtp_q;
	logic filt_q;
	logic [7:0] watch_q;

	state_t state_q;
	in_item_t item_q;
	logic [IdxW:0] rd_idx_q;      // address issued
	logic [IdxW:0] cmp_idx_q;     // entry whose data sits in rd_s1
	logic cmp_vld_q;
	logic hit_q, free_q, best_q;
	logic [IdxW-1:0] hit_idx_q, free_idx_q, best_idx_q;
	logic [31:0] hit_refr_q;
	logic [31:0] best_exp_q, best_addr_q;
	logic [CntW-1:0] exp_cnt_q;   // expired entries seen in this scan
	logic [31:0] now_q;
	logic [63:0] serial_q;
	logic [CntW-1:0] count_q;
	logic del_any_q;
	logic wr_en;
	logic [IdxW-1:0] wr_idx;
	logic [95:0] wr_data;

	assign in_ready = (state_q == ST_IDLE) && !out_valid;
	assign cfg_ready = in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 32'd86400;
			refr_q <= 32'd3600;
			filt_q <= 1'b0;
			watch_q <= 8'd0;
			trap_a_q <= 32'hd82e0500;
			trap_b_q <= 32'hd82e050f;
			smtp_q <= 32'hd82e0509;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HOLD: hold_q <= cfg_data;
				REG_REFRESH: refr_q <= cfg_data;
				REG_FILTER: filt_q <= cfg_data[0];
				REG_WATCH: watch_q <= cfg_data[7:0];
				REG_TRAP_A: trap_a_q <= cfg_data;
				REG_TRAP_B: trap_b_q <= cfg_data;
				REG_SMTP: smtp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_data;
		rd_s1 <= mem[rd_idx_q[IdxW-1:0]];
	end

	// packet classification
	logic filtered, is_v4, nb_hit, trap_hit, smtp_hit, want_list;
	always_comb begin
		filtered = filt_q && (item_q.arrival_interface == watch_q);
		is_v4 = item_q.ip_version == 4'd4;
		nb_hit = is_v4 && !item_q.is_fragment
			&& (item_q.protocol == PROTO_TCP || item_q.protocol == PROTO_UDP)
			&& item_q.dest_port >= PORT_NB_LO && item_q.dest_port <= PORT_NB_HI;
		trap_hit = item_q.dest_addr == trap_a_q || item_q.dest_addr == trap_b_q;
		smtp_hit = item_q.dest_addr == smtp_q && is_v4 && item_q.protocol == PROTO_TCP
			&& item_q.dest_port == PORT_SMTP;
		want_list = nb_hit || (!(is_v4 && item_q.is_fragment) && (trap_hit || smtp_hit));
	end

	logic [31:0] new_exp, new_refr;
	assign new_exp = sat_add(now_q, hold_q);
	assign new_refr = sat_add(now_q, refr_q);

	logic [31:0] e_addr, e_exp, e_refr;
	assign e_addr = rd_s1[95:64];
	assign e_exp = rd_s1[63:32];
	assign e_refr = rd_s1[31:0];

	// notice length for listed and freshened results: packets only
	logic [15:0] note_len;
	assign note_len = (item_q.command == CMD_PACKET) ? item_q.packet_length : 16'd0;

	// write port: refresh of a hit entry, or a fresh listing
	always_comb begin
		wr_en = 1'b0;
		wr_idx = hit_idx_q;
		wr_data = {item_q.address, new_exp, new_refr};
		if (state_q == ST_WRITE) begin
			if (hit_q) wr_en = 1'b1;
			else if (free_q && count_q < CntW'(Capacity)) begin
				wr_en = 1'b1;
				wr_idx = free_idx_q;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			count_q <= '0;
			now_q <= '0;
			serial_q <= '0;
			out_valid <= 1'b0;
			rd_idx_q <= '0;
			cmp_vld_q <= 1'b0;
			del_any_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						item_q <= in_data;
						del_any_q <= 1'b0;
						out_data.notice_length <= '0;
						out_data.drop <= 1'b0;
						out_data.last <= 1'b1;
						if (in_data.command == CMD_CLEAR) begin
							valid_q <= '0;
							count_q <= '0;
							out_data.event_res <= EV_CLEARED;
							out_data.notice_addr <= '0;
							out_data.entry_count <= '0;
							out_data.change_serial <= serial_q;
							out_valid <= 1'b1;
						end else if (in_data.command == CMD_PACKET || in_data.command == CMD_TICK
							|| in_data.command == CMD_ADD || in_data.command == CMD_DELETE) begin
							if (in_data.command == CMD_TICK) now_q <= sat_add(now_q, 32'd1);
							state_q <= ST_SCAN;
						end else begin
							out_data.event_res <= EV_NOTHING;
							out_data.notice_addr <= '0;
							out_data.entry_count <= 6'(count_q);
							out_data.change_serial <= serial_q;
							out_valid <= 1'b1;
						end
						rd_idx_q <= '0;
						cmp_vld_q <= 1'b0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						best_q <= 1'b0;
						exp_cnt_q <= '0;
					end
				end
				ST_SCAN: begin
					// issue reads and compare the previous entry
					if (rd_idx_q < (IdxW+1)'(Capacity)) rd_idx_q <= rd_idx_q + 1'b1;
					cmp_idx_q <= rd_idx_q;
					cmp_vld_q <= rd_idx_q < (IdxW+1)'(Capacity);
					if (cmp_vld_q) begin
						if (valid_q[cmp_idx_q[IdxW-1:0]]) begin
							if (!hit_q && e_addr == item_q.address) begin
								hit_q <= 1'b1;
								hit_idx_q <= cmp_idx_q[IdxW-1:0];
								hit_refr_q <= e_refr;
							end
							if (item_q.command == CMD_TICK && e_exp <= now_q)
								exp_cnt_q <= exp_cnt_q + 1'b1;
							if (e_exp <= now_q && (!best_q || e_exp < best_exp_q
								|| (e_exp == best_exp_q && e_addr < best_addr_q))
								&& item_q.command == CMD_TICK) begin
								best_q <= 1'b1;
								best_idx_q <= cmp_idx_q[IdxW-1:0];
								best_exp_q <= e_exp;
								best_addr_q <= e_addr;
							end
						end else if (!free_q) begin
							free_q <= 1'b1;
							free_idx_q <= cmp_idx_q[IdxW-1:0];
						end
					end
					// hold until the previous result has left
					if (!cmp_vld_q && rd_idx_q == (IdxW+1)'(Capacity) && !out_valid)
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					unique case (item_q.command)
						CMD_TICK: begin
							if (best_q) begin
								valid_q[best_idx_q] <= 1'b0;
								count_q <= count_q - 1'b1;
								serial_q <= serial_q + 64'd1;
								out_data.change_serial <= serial_q + 64'd1;
								out_data.entry_count <= 6'(count_q - 1'b1);
								out_data.event_res <= EV_DELETED;
								out_data.notice_addr <= best_addr_q;
								// final deletion when this was the only expired entry left
								out_data.last <= (exp_cnt_q == CntW'(1));
								del_any_q <= 1'b1;
								state_q <= ST_OUT;
							end else begin
								out_data.change_serial <= serial_q;
								out_data.entry_count <= 6'(count_q);
								out_data.event_res <= EV_NOTHING;
								out_data.notice_addr <= '0;
								out_data.last <= 1'b1;
								state_q <= del_any_q ? ST_IDLE : ST_OUT;
							end
						end
						CMD_DELETE: begin
							state_q <= ST_OUT;
							if (hit_q) begin
								valid_q[hit_idx_q] <= 1'b0;
								count_q <= count_q - 1'b1;
								serial_q <= serial_q + 64'd1;
								out_data.change_serial <= serial_q + 64'd1;
								out_data.entry_count <= 6'(count_q - 1'b1);
								out_data.event_res <= EV_DELETED;
								out_data.notice_addr <= item_q.address;
							end else begin
								out_data.change_serial <= serial_q;
								out_data.entry_count <= 6'(count_q);
								out_data.event_res <= EV_NOTHING;
								out_data.notice_addr <= '0;
							end
						end
						CMD_PACKET: begin
							out_data.change_serial <= serial_q;
							out_data.entry_count <= 6'(count_q);
							out_data.notice_addr <= item_q.address;
							if (!filtered) begin
								out_data.event_res <= EV_PASS;
								state_q <= ST_OUT;
							end else if (hit_q) begin
								out_data.drop <= 1'b1;
								if (now_q > hit_refr_q) state_q <= ST_WRITE;
								else begin
									out_data.event_res <= EV_DROPPED;
									state_q <= ST_OUT;
								end
							end else if (want_list) begin
								out_data.drop <= 1'b1;
								state_q <= ST_WRITE;
							end else begin
								out_data.event_res <= EV_PASS;
								state_q <= ST_OUT;
							end
						end
						default: begin
							// manual add
							out_data.change_serial <= serial_q;
							out_data.entry_count <= 6'(count_q);
							out_data.notice_addr <= item_q.address;
							state_q <= ST_WRITE;
						end
					endcase
				end
				ST_WRITE: begin
					state_q <= ST_OUT;
					if (hit_q) begin
						serial_q <= serial_q + 64'd1;
						out_data.change_serial <= serial_q + 64'd1;
						out_data.event_res <= EV_FRESHENED;
						out_data.notice_length <= note_len;
					end else if (free_q && count_q < CntW'(Capacity)) begin
						valid_q[free_idx_q] <= 1'b1;
						count_q <= count_q + 1'b1;
						serial_q <= serial_q + 64'd1;
						out_data.change_serial <= serial_q + 64'd1;
						out_data.entry_count <= 6'(count_q + 1'b1);
						out_data.event_res <= EV_LISTED;
						out_data.notice_length <= note_len;
					end else begin
						out_data.event_res <= EV_FULL;
						out_data.notice_length <= '0;
					end
				end
				ST_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						if (item_q.command == CMD_TICK && !out_data.last) begin
							// look for the next expired entry
							state_q <= ST_SCAN;
							rd_idx_q <= '0;
							cmp_vld_q <= 1'b0;
							hit_q <= 1'b0;
							free_q <= 1'b0;
							best_q <= 1'b0;
							exp_cnt_q <= '0;
						end else state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/ipbl_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ipbl_checker: port-level checks for the IP blocklist
// Watches handshakes and result fields over time.
// ---------------------------------------------------------------------------
module ipbl_checker
	import ipbl_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire out_item_t out_data
);
	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	// no new transaction while a result waits
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted with result pending");
	// count never beyond capacity
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.entry_count <= 6'(Capacity))
		else $error("entry count out of range");
	// drop only on packet events
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.drop |-> out_data.event_res != EV_PASS
			&& out_data.event_res != EV_DELETED && out_data.event_res != EV_CLEARED
			&& out_data.event_res != EV_NOTHING)
		else $error("drop on a non-packet event");
endmodule

bind ip_blocklist_with_aging ipbl_checker u_ipbl_checker (.*);
`default_nettype wire

/* sim/ip_blocklist_with_aging_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ip_blocklist_with_aging_tb: self-checking bench for the IP blocklist
// Directed tables and a capacity fill, then random traffic, all checked against a local model.
// Both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
module ip_blocklist_with_aging_tb;
	import ipbl_pkg::*;

	localparam int WatchLimit = 20000;
	localparam int NumRandom = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	ip_blocklist_with_aging i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Model state
	logic [31:0] m_hold, m_refresh, m_trap_a, m_trap_b, m_smtp;
	logic m_filter;
	logic [7:0] m_watch;
	logic m_valid [Capacity];
	logic [31:0] m_addr [Capacity];
	logic [31:0] m_expiry [Capacity];
	logic [31:0] m_fresh_at [Capacity];
	logic [5:0] m_count;
	logic [31:0] m_now;
	logic [63:0] m_serial;

	out_item_t pending_results[$];
	int fail_count = 0;
	int idle_pct = 12;
	int quiet_cycles = 0;
	bit draining = 1'b0;

	task automatic report(input string what, input out_item_t got, input out_item_t want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic int find_entry(input logic [31:0] a);
		for (int i = 0; i < Capacity; i++)
			if (m_valid[i] && m_addr[i] == a) return i;
		return -1;
	endfunction

	function automatic void renew(input int i);
		m_expiry[i] = add_sat(m_now, m_hold);
		m_fresh_at[i] = add_sat(m_now, m_refresh);
		m_serial++;
	endfunction

	function automatic void push_result(input event_t ev, input logic drp,
			input logic [31:0] a, input logic [15:0] len);
		out_item_t r;
		r.event_res = ev;
		r.drop = drp;
		r.notice_addr = a;
		r.notice_length = len;
		r.entry_count = m_count;
		r.change_serial = m_serial;
		r.last = 1'b0;
		pending_results.push_back(r);
	endfunction

	function automatic void block_source(input logic [31:0] a, input logic [15:0] len,
			input logic drp);
		int i;
		i = -1;
		if (m_count < Capacity)
			for (int k = Capacity - 1; k >= 0; k--)
				if (!m_valid[k]) i = k;
		if (i < 0) begin
			push_result(EV_FULL, drp, a, 16'd0);
			return;
		end
		m_valid[i] = 1'b1;
		m_addr[i] = a;
		m_count++;
		renew(i);
		push_result(EV_LISTED, drp, a, len);
	endfunction

	// Work out the results of one accepted transaction
	function automatic void predict_results(input in_item_t it);
		int i, n0, best;
		n0 = pending_results.size();
		case (cmd_t'(it.command))
			CMD_PACKET: begin
				if (!m_filter || it.arrival_interface != m_watch)
					push_result(EV_PASS, 1'b0, it.address, 16'd0);
				else begin
					i = find_entry(it.address);
					if (i >= 0) begin
						if (m_now > m_fresh_at[i]) begin
							renew(i);
							push_result(EV_FRESHENED, 1'b1, it.address, it.packet_length);
						end else
							push_result(EV_DROPPED, 1'b1, it.address, 16'd0);
					end else if (it.ip_version == 4'd4 && it.is_fragment)
						push_result(EV_PASS, 1'b0, it.address, 16'd0);
					else if (it.ip_version == 4'd4
							&& (it.protocol == PROTO_TCP || it.protocol == PROTO_UDP)
							&& it.dest_port >= PORT_NB_LO && it.dest_port <= PORT_NB_HI)
						block_source(it.address, it.packet_length, 1'b1);
					else if (it.dest_addr == m_trap_a || it.dest_addr == m_trap_b)
						block_source(it.address, it.packet_length, 1'b1);
					else if (it.dest_addr == m_smtp && it.ip_version == 4'd4
							&& it.protocol == PROTO_TCP && it.dest_port == PORT_SMTP)
						block_source(it.address, it.packet_length, 1'b1);
					else
						push_result(EV_PASS, 1'b0, it.address, 16'd0);
				end
			end
			CMD_TICK: begin
				m_now = add_sat(m_now, 32'd1);
				forever begin
					best = -1;
					for (int k = 0; k < Capacity; k++) begin
						if (!m_valid[k] || m_expiry[k] > m_now) continue;
						if (best < 0 || m_expiry[k] < m_expiry[best]
								|| (m_expiry[k] == m_expiry[best] && m_addr[k] < m_addr[best]))
							best = k;
					end
					if (best < 0) break;
					m_valid[best] = 1'b0;
					if (m_count > 0) m_count--;
					m_serial++;
					push_result(EV_DELETED, 1'b0, m_addr[best], 16'd0);
				end
				if (pending_results.size() == n0)
					push_result(EV_NOTHING, 1'b0, 32'd0, 16'd0);
			end
			CMD_ADD: begin
				i = find_entry(it.address);
				if (i >= 0) begin
					renew(i);
					push_result(EV_FRESHENED, 1'b0, it.address, 16'd0);
				end else
					block_source(it.address, 16'd0, 1'b0);
			end
			CMD_DELETE: begin
				i = find_entry(it.address);
				if (i >= 0) begin
					m_valid[i] = 1'b0;
					if (m_count > 0) m_count--;
					m_serial++;
					push_result(EV_DELETED, 1'b0, it.address, 16'd0);
				end else
					push_result(EV_NOTHING, 1'b0, 32'd0, 16'd0);
			end
			CMD_CLEAR: begin
				for (int k = 0; k < Capacity; k++) m_valid[k] = 1'b0;
				m_count = '0;
				push_result(EV_CLEARED, 1'b0, 32'd0, 16'd0);
			end
			default: push_result(EV_NOTHING, 1'b0, 32'd0, 16'd0);
		endcase
		pending_results[pending_results.size() - 1].last = 1'b1;
	endfunction

	function automatic void model_reset();
		m_hold = 32'd86400;
		m_refresh = 32'd3600;
		m_filter = 1'b0;
		m_watch = 8'd0;
		m_trap_a = 32'hd82e0500;
		m_trap_b = 32'hd82e050f;
		m_smtp = 32'hd82e0509;
		for (int k = 0; k < Capacity; k++) begin
			m_valid[k] = 1'b0;
			m_addr[k] = '0;
			m_expiry[k] = '0;
			m_fresh_at[k] = '0;
		end
		m_count = '0;
		m_now = '0;
		m_serial = '0;
	endfunction

	// Result checking and watchdog
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WatchLimit) begin
				$display("watchdog expired, %0d results pending", pending_results.size());
				$display("CHECK FAILED");
				$finish;
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0)
					report("unexpected result", out_data, '0);
				else begin
					want = pending_results.pop_front();
					if (out_data.event_res !== want.event_res) report("event_res", out_data, want);
					else if (out_data.drop !== want.drop) report("drop", out_data, want);
					else if (out_data.notice_addr !== want.notice_addr)
						report("notice_addr", out_data, want);
					else if (out_data.notice_length !== want.notice_length)
						report("notice_length", out_data, want);
					else if (out_data.entry_count !== want.entry_count)
						report("entry_count", out_data, want);
					else if (out_data.change_serial !== want.change_serial)
						report("change_serial", out_data, want);
					else if (out_data.last !== want.last) report("last", out_data, want);
				end
			end
		end
	end

	// Receiver stalls
	always @(negedge clk) begin
		out_ready <= draining || ($urandom_range(99) >= idle_pct);
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_HOLD: m_hold = val;
			REG_REFRESH: m_refresh = val;
			REG_FILTER: m_filter = val[0];
			REG_WATCH: m_watch = val[7:0];
			REG_TRAP_A: m_trap_a = val;
			REG_TRAP_B: m_trap_b = val;
			REG_SMTP: m_smtp = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Send one transaction; checks row expectation when given
	task automatic send_item(input in_item_t it, input bit has_want, input event_t want_ev);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) @(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_results(it);
		if (has_want && pending_results[$].event_res != want_ev)
			report("directed row", pending_results[$], '0);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40 * 34) @(posedge clk);
	endtask

	function automatic in_item_t make_item(input cmd_t c, input logic [31:0] src,
			input logic [31:0] dst, input logic [7:0] proto, input logic [15:0] port);
		in_item_t it;
		it.command = c;
		it.address = src;
		it.dest_addr = dst;
		it.ip_version = 4'd4;
		it.is_fragment = 1'b0;
		it.protocol = proto;
		it.dest_port = port;
		it.arrival_interface = 8'd0;
		it.packet_length = 16'(40 + $urandom_range(1500));
		return it;
	endfunction

	typedef struct {
		in_item_t it;
		bit has_want;
		event_t want_ev;
	} dir_row_t;

	// Random source from a small pool so that hits recur
	function automatic logic [31:0] pick_source();
		if ($urandom_range(3) == 0) return $urandom();
		return 32'h0a00_0000 | 32'($urandom_range(39));
	endfunction

	initial begin
		dir_row_t rows[$];
		dir_row_t r;
		in_item_t it;
		int pick;
		model_reset();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table, at reset settings then with filtering on
		r.has_want = 1'b1;
		r.it = make_item(CMD_PACKET, 32'hFFFF_FFFF, 32'hd82e0500, PROTO_TCP, 16'd137);
		r.want_ev = EV_PASS; rows.push_back(r);
		r.it = make_item(CMD_TICK, '0, '0, '0, '0);
		r.want_ev = EV_NOTHING; rows.push_back(r);
		r.it = make_item(CMD_DELETE, 32'h1, '0, '0, '0);
		r.want_ev = EV_NOTHING; rows.push_back(r);
		r.it = make_item(CMD_CLEAR, '0, '0, '0, '0);
		r.want_ev = EV_CLEARED; rows.push_back(r);
		for (int c = 5; c < 8; c++) begin
			r.it = make_item(cmd_t'(c), 32'hFFFF_FFFF, '1, '1, '1);
			r.want_ev = EV_NOTHING; rows.push_back(r);
		end
		foreach (rows[k]) send_item(rows[k].it, rows[k].has_want, rows[k].want_ev);
		rows.delete();
		wait_idle();
		write_reg(REG_FILTER, 32'd1);
		write_reg(REG_WATCH, 32'd255);
		write_reg(REG_HOLD, 32'd3);
		write_reg(REG_REFRESH, 32'd0);

		r.has_want = 1'b0;
		r.it = make_item(CMD_PACKET, 32'h0, '0, PROTO_TCP, 16'd137);
		r.it.arrival_interface = 8'd255; rows.push_back(r);
		r.it.address = 32'hFFFF_FFFF; r.it.protocol = PROTO_UDP; r.it.dest_port = 16'd139;
		rows.push_back(r);
		r.it.address = 32'h5; r.it.dest_port = 16'd140; rows.push_back(r);
		r.it.is_fragment = 1'b1; r.it.dest_addr = 32'hd82e050f; rows.push_back(r);
		r.it.is_fragment = 1'b0; rows.push_back(r);
		r.it = make_item(CMD_PACKET, 32'h6, 32'hd82e0509, PROTO_TCP, 16'd25);
		r.it.arrival_interface = 8'd255; r.it.packet_length = 16'hFFFF; rows.push_back(r);
		r.it.ip_version = 4'd6; r.it.address = 32'h7; rows.push_back(r);
		r.it.dest_addr = 32'hd82e0500; rows.push_back(r);
		r.it = make_item(CMD_TICK, '0, '0, '0, '0); rows.push_back(r);
		r.it = make_item(CMD_PACKET, 32'h0, '0, '0, '0);
		r.it.arrival_interface = 8'd255; rows.push_back(r);
		r.it = make_item(CMD_ADD, 32'h0, '0, '0, '0); rows.push_back(r);
		r.it = make_item(CMD_ADD, 32'h1234, '0, '0, '0); rows.push_back(r);
		r.it = make_item(CMD_DELETE, 32'h1234, '0, '0, '0); rows.push_back(r);
		for (int k = 0; k < 4; k++) begin
			r.it = make_item(CMD_TICK, '0, '0, '0, '0); rows.push_back(r);
		end
		foreach (rows[k]) send_item(rows[k].it, rows[k].has_want, rows[k].want_ev);
		wait_idle();

		// Fill past capacity at saturating hold time, then clear
		write_reg(REG_HOLD, 32'hFFFF_FFFF);
		write_reg(REG_REFRESH, 32'hFFFF_FFFF);
		for (int k = 0; k <= Capacity; k++)
			send_item(make_item(CMD_ADD, 32'h2000_0000 + 32'(k), '0, '0, '0), 1'b0, EV_PASS);
		it = make_item(CMD_PACKET, 32'h3000_0000, 32'hd82e050f, '0, '0);
		it.arrival_interface = 8'd255;
		send_item(it, 1'b1, EV_FULL);
		send_item(make_item(CMD_CLEAR, '0, '0, '0, '0), 1'b1, EV_CLEARED);
		wait_idle();

		write_reg(REG_HOLD, 32'd1);
		write_reg(REG_REFRESH, 32'd2);
		write_reg(REG_WATCH, 32'd3);
		write_reg(REG_TRAP_A, 32'hC0A8_0001);
		write_reg(REG_TRAP_B, 32'h0);
		write_reg(REG_SMTP, 32'hFFFF_FFFF);

		// Random traffic in three phases with changing settings
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				write_reg(REG_HOLD, 32'd4 + $urandom_range(12));
				write_reg(REG_REFRESH, $urandom_range(5));
			end
			if (ph == 2) begin
				write_reg(REG_FILTER, 32'd0);
				write_reg(REG_FILTER, 32'd1);
				write_reg(REG_WATCH, 32'd0);
			end
			idle_pct = (ph == 1) ? 0 : 12;
			for (int n = 0; n < NumRandom / 3; n++) begin
				pick = $urandom_range(99);
				it = '0;
				it.address = pick_source();
				it.packet_length = 16'($urandom());
				it.arrival_interface = ($urandom_range(9) == 0) ? 8'($urandom()) : m_watch;
				it.ip_version = ($urandom_range(7) == 0) ? 4'($urandom()) : 4'd4;
				it.is_fragment = ($urandom_range(7) == 0);
				it.protocol = ($urandom_range(1)) ? PROTO_TCP : PROTO_UDP;
				it.dest_addr = $urandom();
				it.dest_port = 16'($urandom());
				if (pick < 50) begin
					it.command = CMD_PACKET;
					case ($urandom_range(4))
						0: it.dest_port = PORT_NB_LO + 16'($urandom_range(2));
						1: it.dest_addr = m_trap_a;
						2: it.dest_addr = m_trap_b;
						3: begin
							it.dest_addr = m_smtp;
							it.dest_port = PORT_SMTP;
						end
						default: it.protocol = 8'($urandom());
					endcase
				end else if (pick < 72) it.command = CMD_TICK;
				else if (pick < 84) it.command = CMD_ADD;
				else if (pick < 94) it.command = CMD_DELETE;
				else if (pick < 97) it.command = CMD_CLEAR;
				else it.command = 3'($urandom_range(7));
				send_item(it, 1'b0, EV_PASS);
				if (n == 30 && ph == 0) wait_idle();
			end
			wait_idle();
		end

		draining = 1'b1;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

/* ip_blocklist_with_aging.f */
hw/rtl/ipbl_pkg.sv
hw/rtl/ip_blocklist_with_aging.sv
hw/rtl/ipbl_checker.sv
sim/ip_blocklist_with_aging_tb.sv
